[design/mbhs_pkg.sv]
// Shared types and constants for the media box header scanner.
// Used by mbhs_parser, media_box_header_scanner_top and the testbench; depends on nothing.
package mbhs_pkg;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_END   = 2'd1;

  // Result status codes.
  localparam logic [1:0] ST_NORMAL   = 2'd0;
  localparam logic [1:0] ST_TO_END   = 2'd1;
  localparam logic [1:0] ST_BAD_SIZE = 2'd2;

  // Four-character code 'uuid'.
  localparam logic [31:0] TYPE_UUID = 32'h7575_6964;

  // Header lengths.
  localparam logic [5:0] HLEN_BASE  = 6'd8;
  localparam logic [5:0] HLEN_LARGE = 6'd8;
  localparam logic [5:0] HLEN_UUID  = 6'd16;

  // One word on the result channel.
  typedef struct packed {
    logic [63:0] box_offset;
    logic [63:0] box_size;
    logic [31:0] box_type;
    logic [5:0]  header_length;
    logic [63:0] uuid_upper;
    logic [63:0] uuid_lower;
    logic [1:0]  status;
    logic        last;
  } mbhs_result_t;

endpackage

[design/media_box_header_scanner_top.sv]
// Top level of the media box header scanner: configuration registers,
// input register, output register. Depends on mbhs_pkg and mbhs_parser.
//
// The scanner walks a region of a box-structured media file, one byte per
// word on the input channel, starting at region_start. For every box header
// it reads (32-bit size, 32-bit type, optional 64-bit large size, optional
// 16-byte uuid) it delivers one result word with the box offset, total size,
// type, header length, uuid and a status, and then skips the box payload by
// counting bytes. The scan ends on a size of zero (status 1, size runs to
// region_end), on a size smaller than the header (status 2; discard the whole
// run), or on a box that reaches region_end; that result carries last = 1 and
// later bytes are dropped without a result. The block takes one byte every
// clock cycle while the output register has room: a byte is held
// in the input register, and the result it completes is loaded into
// the output register when the parser steps on that byte. Every byte
// updates the scan position, header count and payload counter. The
// output register holds a result until it is taken;
// while a result waits under out_stall, the input side stalls after one more
// byte. Writing region_start or region_end restarts the scan; write them only
// while no byte is in flight. Offsets are OFFSET_BITS wide and wrap; written
// offsets are truncated to that width.
module media_box_header_scanner_top #(
  parameter int OFFSET_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mbhs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data,
  // Input byte channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_data_byte,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [63:0]                   out_box_offset,
  output logic [63:0]                   out_box_size,
  output logic [31:0]                   out_box_type,
  output logic [5:0]                    out_header_length,
  output logic [63:0]                   out_uuid_upper,
  output logic [63:0]                   out_uuid_lower,
  output logic [1:0]                    out_status,
  output logic                          out_last
);
  import mbhs_pkg::*;

  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [OFFSET_BITS-1:0] end_r, end_nxt;
  logic                   cfg_wr;

  logic                   in_vld_r;
  logic [7:0]             in_byte_r;
  logic                   out_vld_r;
  mbhs_result_t           out_r;

  logic                   out_room;
  logic                   step;
  logic                   in_acc;
  logic                   res_vld;
  mbhs_result_t           res;

  // Configuration is always accepted; the scan restarts on a valid write to region_start or region_end.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready
                   && (cfg_index == REG_REGION_START || cfg_index == REG_REGION_END);

  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REGION_START: start_nxt = cfg_data[OFFSET_BITS-1:0];
        REG_REGION_END:   end_nxt   = cfg_data[OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= '0;
    end else begin
      start_r <= start_nxt;
      end_r   <= end_nxt;
    end
  end

  // The parser advances whenever a byte waits in the input register and the output register can take a result.
  assign out_room = !out_vld_r || !out_stall;
  assign step     = in_vld_r && out_room;
  assign in_stall = in_vld_r && !out_room;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_data_byte;
    end
  end

  mbhs_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (cfg_wr),
    .restart_pos (start_nxt),
    .restart_fin (start_nxt >= end_nxt),
    .region_end  (end_r),
    .step        (step),
    .data_byte   (in_byte_r),
    .res_vld     (res_vld),
    .res         (res)
  );

  // Output register: loads a new result or drains when the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_vld) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_box_offset    = out_r.box_offset;
  assign out_box_size      = out_r.box_size;
  assign out_box_type      = out_r.box_type;
  assign out_header_length = out_r.header_length;
  assign out_uuid_upper    = out_r.uuid_upper;
  assign out_uuid_lower    = out_r.uuid_lower;
  assign out_status        = out_r.status;
  assign out_last          = out_r.last;

endmodule

[design/mbhs_parser.sv]
// Header parser core: scan position, header byte assembly, payload skip
// counter and result formation. Depends on mbhs_pkg.
module mbhs_parser #(
  parameter int OFFSET_BITS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     restart,
  input  logic [OFFSET_BITS-1:0]   restart_pos,
  input  logic                     restart_fin,
  input  logic [OFFSET_BITS-1:0]   region_end,
  input  logic                     step,
  input  logic [7:0]               data_byte,
  output logic                     res_vld,
  output mbhs_pkg::mbhs_result_t   res
);
  import mbhs_pkg::*;

  // Largest offset, zero-extended to 64 bits.
  localparam logic [63:0] OFS_MASK = (OFFSET_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                   : ((64'd1 << OFFSET_BITS) - 64'd1);

  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] box_start_r, box_start_nxt;
  logic [OFFSET_BITS-1:0] dist_r;
  logic                   be_past_r;
  logic [4:0]             cnt_r, cnt_nxt;
  logic [31:0]            size_r, size_nxt;
  logic [31:0]            type_r, type_nxt;
  logic [63:0]            large_r, large_nxt;
  logic [63:0]            uhi_r, uhi_nxt;
  logic [63:0]            ulo_r, ulo_nxt;
  logic [63:0]            rem_r, rem_nxt;
  logic                   fin_r, fin_nxt;

  logic [31:0] sw, tw;
  logic [63:0] lw, uh, ul;
  logic [4:0]  uuid_at;
  logic [5:0]  hlen;
  logic [5:0]  k_inc;
  logic [63:0] size;
  logic [63:0] room;
  logic        last;
  logic [1:0]  status;

  // Distance to the region end and whether the box starts at or past it.
  // Valid well before a header completes, since a header has at least 8 bytes.
  always_ff @(posedge clk) begin
    dist_r    <= region_end - box_start_r;
    be_past_r <= (box_start_r >= region_end);
  end

  always_comb begin
    pos_nxt       = pos_r;
    box_start_nxt = box_start_r;
    cnt_nxt       = cnt_r;
    size_nxt      = size_r;
    type_nxt      = type_r;
    large_nxt     = large_r;
    uhi_nxt       = uhi_r;
    ulo_nxt       = ulo_r;
    rem_nxt       = rem_r;
    fin_nxt       = fin_r;
    res_vld       = 1'b0;
    last          = 1'b0;
    status        = ST_NORMAL;

    // Start of a header clears the assembled words.
    sw = (cnt_r == 5'd0) ? 32'd0 : size_r;
    tw = (cnt_r == 5'd0) ? 32'd0 : type_r;
    lw = (cnt_r == 5'd0) ? 64'd0 : large_r;
    uh = (cnt_r == 5'd0) ? 64'd0 : uhi_r;
    ul = (cnt_r == 5'd0) ? 64'd0 : ulo_r;

    uuid_at = (cnt_r >= 5'd8 && sw == 32'd1) ? 5'd16 : 5'd8;
    if (cnt_r < 5'd4) begin
      sw = {sw[23:0], data_byte};
    end else if (cnt_r < 5'd8) begin
      tw = {tw[23:0], data_byte};
    end else if (cnt_r < uuid_at) begin
      lw = {lw[55:0], data_byte};
    end else if (cnt_r < uuid_at + 5'd8) begin
      uh = {uh[55:0], data_byte};
    end else begin
      ul = {ul[55:0], data_byte};
    end

    hlen = HLEN_BASE + ((sw == 32'd1) ? HLEN_LARGE : 6'd0)
         + ((tw == TYPE_UUID) ? HLEN_UUID : 6'd0);
    k_inc = {1'b0, cnt_r} + 6'd1;
    size  = (sw == 32'd1) ? lw : {32'd0, sw};
    room  = OFS_MASK - 64'(box_start_nxt);

    if (size == 64'd0) begin
      size   = 64'(dist_r);
      status = ST_TO_END;
      last   = 1'b1;
    end else if (size < 64'(hlen)) begin
      status = ST_BAD_SIZE;
      last   = 1'b1;
    end else if (size > room || be_past_r || size >= 64'(dist_r)) begin
      last   = 1'b1;
    end

    if (step && !fin_r) begin
      pos_nxt = pos_r + OFFSET_BITS'(1);
      if (rem_r != 64'd0) begin
        rem_nxt = rem_r - 64'd1;
      end else begin
        if (cnt_r == 5'd0) begin
          box_start_nxt = pos_r;
        end
        size_nxt  = sw;
        type_nxt  = tw;
        large_nxt = lw;
        uhi_nxt   = uh;
        ulo_nxt   = ul;
        if (k_inc < hlen) begin
          cnt_nxt = k_inc[4:0];
        end else begin
          cnt_nxt = 5'd0;
          res_vld = 1'b1;
          if (last) begin
            fin_nxt = 1'b1;
          end else begin
            rem_nxt = size - 64'(hlen);
          end
        end
      end
    end

    res.box_offset    = 64'(box_start_nxt);
    res.box_size      = size;
    res.box_type      = tw;
    res.header_length = hlen;
    res.uuid_upper    = uh;
    res.uuid_lower    = ul;
    res.status        = status;
    res.last          = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cnt_r <= 5'd0;
      rem_r <= 64'd0;
      fin_r <= 1'b1;
    end else if (restart) begin
      pos_r <= restart_pos;
      cnt_r <= 5'd0;
      rem_r <= 64'd0;
      fin_r <= restart_fin;
    end else begin
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
      rem_r <= rem_nxt;
      fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    box_start_r <= box_start_nxt;
    size_r      <= size_nxt;
    type_r      <= type_nxt;
    large_r     <= large_nxt;
    uhi_r       <= uhi_nxt;
    ulo_r       <= ulo_nxt;
  end

endmodule

[dv/testbench.sv]
// Self-checking testbench for media_box_header_scanner_top: byte streams of box headers
// and payloads in, one result word per completed header out. Depends on mbhs_pkg and
// the scanner RTL; holds its own cycle-free scan predictor for the expected words.
module testbench;
  import mbhs_pkg::*;

  localparam int OFFSET_BITS = 64;
  localparam logic [63:0] OFS_MASK =
    (OFFSET_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << OFFSET_BITS) - 64'd1);

  // Random part length in scanned bytes, and the receiver's long hold-off in cycles.
  localparam int SCAN_BYTES = 450;
  localparam int HOLD_CYCLES = 150;

  // A few ordinary four-character codes for the directed words.
  localparam logic [31:0] T_FTYP = 32'h6674_7970;
  localparam logic [31:0] T_MOOV = 32'h6d6f_6f76;
  localparam logic [31:0] T_MDAT = 32'h6d64_6174;
  localparam logic [31:0] T_FREE = 32'h6672_6565;

  typedef enum int {
    BK_PLAIN, BK_LARGE, BK_UUID, BK_LARGE_UUID, BK_TO_END, BK_BAD, BK_HUGE
  } box_kind_t;

  // One directed case: optional region setup, one box header, some payload bytes, and
  // where the answer is obvious, the result word typed in by hand.
  typedef struct {
    bit           set_region;
    logic [63:0]  rgn_lo;
    logic [63:0]  rgn_hi;
    logic [31:0]  size_field;
    logic [31:0]  type_field;
    logic [63:0]  large_field;
    logic [63:0]  uuid_hi_field;
    logic [63:0]  uuid_lo_field;
    int           pay_len;
    bit           typed;
    mbhs_result_t answer;
  } box_case_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_data_byte;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] out_box_offset;
  logic [63:0] out_box_size;
  logic [31:0] out_box_type;
  logic [5:0] out_header_length;
  logic [63:0] out_uuid_upper;
  logic [63:0] out_uuid_lower;
  logic [1:0] out_status;
  logic out_last;

  media_box_header_scanner_top #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_box_offset    (out_box_offset),
    .out_box_size      (out_box_size),
    .out_box_type      (out_box_type),
    .out_header_length (out_header_length),
    .out_uuid_upper    (out_uuid_upper),
    .out_uuid_lower    (out_uuid_lower),
    .out_status        (out_status),
    .out_last          (out_last)
  );

  always #5 clk = ~clk;

  // Predictor copy of the registers and the scan state.
  logic [63:0] rgn_start, rgn_end;
  logic [63:0] scan_pos, box_at, large_w, uuid_hi, uuid_lo, skip_left;
  logic [31:0] size_w, type_w;
  logic [4:0]  hdr_cnt;
  bit          scan_done;

  // Expected result words, oldest first, and the bookkeeping around them.
  mbhs_result_t box_words_q[$];
  mbhs_result_t typed_res;
  bit           typed_on = 1'b0;
  int           fail_cnt = 0;
  int           words_seen = 0;
  int           scanned_bytes = 0;

  // Stimulus control shared between the sender, the receiver and the main sequence.
  logic [7:0] stream_q[$];
  int         in_idle_pct = 21;
  int         out_idle_pct = 21;
  bit         hold_req = 1'b0;
  int         hold_left = 0;

  function automatic void restart_scan();
    scan_pos  = rgn_start;
    box_at    = '0;
    hdr_cnt   = '0;
    size_w    = '0;
    type_w    = '0;
    large_w   = '0;
    uuid_hi   = '0;
    uuid_lo   = '0;
    skip_left = '0;
    scan_done = (rgn_start >= rgn_end);
  endfunction

  // Advances the scan by one byte; returns 1 when the byte completes a header, with the
  // result word that the header yields.
  function automatic bit scan_byte(input logic [7:0] b, output mbhs_result_t r);
    int unsigned k, hlen, uuid_at;
    logic [63:0] size, room;
    logic [1:0]  st;
    logic        lst;
    r = '0;
    st = ST_NORMAL;
    lst = 1'b0;
    if (scan_done) return 1'b0;
    // Payload bytes only move the position.
    if (skip_left != 0) begin
      skip_left = skip_left - 64'd1;
      scan_pos = (scan_pos + 64'd1) & OFS_MASK;
      return 1'b0;
    end
    k = hdr_cnt;
    if (k == 0) begin
      box_at  = scan_pos;
      size_w  = '0;
      type_w  = '0;
      large_w = '0;
      uuid_hi = '0;
      uuid_lo = '0;
    end
    scan_pos = (scan_pos + 64'd1) & OFS_MASK;
    // The uuid bytes sit behind the large size when there is one.
    uuid_at = (k >= 8 && size_w == 32'd1) ? 16 : 8;
    if (k < 4)                 size_w  = {size_w[23:0], b};
    else if (k < 8)            type_w  = {type_w[23:0], b};
    else if (k < uuid_at)      large_w = {large_w[55:0], b};
    else if (k < uuid_at + 8)  uuid_hi = {uuid_hi[55:0], b};
    else                       uuid_lo = {uuid_lo[55:0], b};
    hlen = 8 + ((size_w == 32'd1) ? 8 : 0) + ((type_w == TYPE_UUID) ? 16 : 0);
    if (k + 1 < hlen) begin
      hdr_cnt = 5'(k + 1);
      return 1'b0;
    end
    hdr_cnt = '0;
    size = (size_w == 32'd1) ? large_w : {32'd0, size_w};
    if (size == 0) begin
      size = (rgn_end - box_at) & OFS_MASK;
      st = ST_TO_END;
      lst = 1'b1;
    end else if (size < hlen) begin
      st = ST_BAD_SIZE;
      lst = 1'b1;
    end else begin
      // A box whose end lies past the offset range counts as reaching the region end.
      room = OFS_MASK - box_at;
      if (size > room || box_at + size >= rgn_end) lst = 1'b1;
      else skip_left = size - 64'(hlen);
    end
    if (lst) scan_done = 1'b1;
    r = '{box_at, size, type_w, 6'(hlen), uuid_hi, uuid_lo, st, lst};
    return 1'b1;
  endfunction

  function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("mismatch in %s: expected %h, got %h", name, want, got);
    end
  endfunction

  // Everything is sampled at the rising edge, before the block's registers move. Result
  // words are checked first, then register writes and accepted bytes feed the predictor.
  always @(posedge clk) begin : mon
    mbhs_result_t got, want;
    if (!rst_n) begin
      rgn_start = '0;
      rgn_end = '0;
      restart_scan();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_box_offset, out_box_size, out_box_type, out_header_length,
                out_uuid_upper, out_uuid_lower, out_status, out_last};
        words_seen++;
        if (box_words_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("result word at offset %h with no expected word waiting", got.box_offset);
        end else begin
          want = box_words_q.pop_front();
          cmp_field("box_offset", want.box_offset, got.box_offset);
          cmp_field("box_size", want.box_size, got.box_size);
          cmp_field("box_type", want.box_type, got.box_type);
          cmp_field("header_length", want.header_length, got.header_length);
          cmp_field("uuid_upper", want.uuid_upper, got.uuid_upper);
          cmp_field("uuid_lower", want.uuid_lower, got.uuid_lower);
          cmp_field("status", want.status, got.status);
          cmp_field("last", want.last, got.last);
        end
      end
      // Either register write restarts the scan.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_REGION_START) begin
          rgn_start = cfg_data & OFS_MASK;
          restart_scan();
        end else if (cfg_index == REG_REGION_END) begin
          rgn_end = cfg_data & OFS_MASK;
          restart_scan();
        end
      end
      if (in_valid && !in_stall) begin
        // Bytes after the end of the scan are dropped and do not count as scanned.
        if (!scan_done) scanned_bytes++;
        if (scan_byte(in_data_byte, want))
          box_words_q.push_back(typed_on ? typed_res : want);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request so that the output word
  // backs up and the block has to stall its input side.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // Both writes go out back to back; valid stays high across them.
  task automatic write_region(input logic [63:0] lo, input logic [63:0] hi);
    cfg_valid <= 1'b1;
    cfg_index <= REG_REGION_START;
    cfg_data <= lo;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= REG_REGION_END;
    cfg_data <= hi;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Waits for every expected word, then lets bytes that make no result drain through
  // the input and output registers before the registers may be written again.
  task automatic settle();
    while (box_words_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_be(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) stream_q.push_back(v[8*i +: 8]);
  endtask

  task automatic put_box(input logic [31:0] sw, input logic [31:0] tw, input logic [63:0] lg,
                         input logic [63:0] uh, input logic [63:0] ul, input int pay);
    put_be(sw, 4);
    put_be(tw, 4);
    if (sw == 32'd1) put_be(lg, 8);
    if (tw == TYPE_UUID) begin
      put_be(uh, 8);
      put_be(ul, 8);
    end
    repeat (pay) stream_q.push_back(8'($urandom_range(255)));
  endtask

  // Builds one random region: mostly a well-formed chain of boxes with random content,
  // often closed by a box that ends the scan, sometimes with a corrupted byte, and with
  // a little trailing noise. A dense region is a long run of bare headers.
  task automatic build_phase(input bit dense, output logic [63:0] lo, output logic [63:0] hi);
    logic [63:0] total, lg;
    logic [31:0] sw, tw;
    int nbox, pay, pick, hl;
    bit ends, top, big, uu;
    box_kind_t kind;
    stream_q.delete();
    total = '0;
    ends = 1'b0;
    top = !dense && ($urandom_range(9) == 0);
    if (top) begin
      // Near the top of the offset range, so positions wrap inside the region.
      lo = OFS_MASK - 64'($urandom_range(96));
    end else if ($urandom_range(7) == 0) begin
      lo = '0;
    end else begin
      lo = {$urandom, $urandom} >> $urandom_range(63);
      if (lo[63:20] == '1) lo[63] = 1'b0;
    end
    nbox = dense ? 10 : $urandom_range(1, 6);
    for (int i = 0; i < nbox && !ends; i++) begin
      pay = dense ? 0 : (($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(4));
      pick = dense ? 0 : $urandom_range(99);
      if (pick < 60)      kind = BK_PLAIN;
      else if (pick < 70) kind = BK_LARGE;
      else if (pick < 78) kind = BK_UUID;
      else if (pick < 83) kind = BK_LARGE_UUID;
      else if (pick < 89) kind = BK_TO_END;
      else if (pick < 95) kind = BK_BAD;
      else                kind = BK_HUGE;
      big = (kind == BK_LARGE || kind == BK_LARGE_UUID || kind == BK_HUGE ||
             ((kind == BK_TO_END || kind == BK_BAD) && $urandom_range(1) == 1));
      uu = (kind == BK_UUID || kind == BK_LARGE_UUID ||
            ((kind == BK_TO_END || kind == BK_BAD) && $urandom_range(3) == 0));
      tw = $urandom;
      if (uu) tw = TYPE_UUID;
      else if (tw == TYPE_UUID) tw = T_FREE;
      hl = 8 + (big ? 8 : 0) + (uu ? 16 : 0);
      sw = big ? 32'd1 : 32'(hl + pay);
      lg = big ? 64'(hl + pay) : 64'd0;
      case (kind)
        BK_TO_END: begin
          sw = big ? 32'd1 : 32'd0;
          lg = '0;
        end
        BK_BAD: begin
          if (big) lg = 64'($urandom_range(1, hl - 1));
          else sw = 32'($urandom_range(2, hl - 1));
        end
        BK_HUGE: lg = {$urandom | 32'd1, $urandom};
        default: ;
      endcase
      ends = (kind == BK_TO_END || kind == BK_BAD || kind == BK_HUGE);
      put_box(sw, tw, lg, {$urandom, $urandom}, {$urandom, $urandom}, ends ? 0 : pay);
      total += 64'(ends ? hl : hl + pay);
    end
    if (top) begin
      hi = OFS_MASK;
    end else begin
      pick = $urandom_range(9);
      if (pick <= 5)      hi = lo + total;
      else if (pick <= 7) hi = lo + total + 64'($urandom_range(1, 500));
      else if (pick == 8) hi = lo + total - 64'($urandom_range(1, int'(total)));
      else                hi = {$urandom, $urandom};
    end
    if ($urandom_range(14) == 0)
      stream_q[$urandom_range(stream_q.size() - 1)] = 8'($urandom_range(255));
    repeat ($urandom_range(6)) stream_q.push_back(8'($urandom_range(255)));
  endtask

  initial begin : main
    box_case_t dir_tab [16];
    logic [63:0] lo, hi;
    int phase, rand_base;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_REGION_START;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data_byte = '0;

    // Directed cases. Rows with a typed answer are simple enough to read straight off
    // the header; the rest go through the predictor.
    dir_tab = '{
      // Right after reset the region is empty, so the header is dropped.
      '{1'b0, 64'h0, 64'h0, 32'd8, T_FTYP, 64'h0, 64'h0, 64'h0, 0, 1'b0, '0},
      '{1'b1, 64'h0, 64'h100, 32'd8, T_FTYP, 64'h0, 64'h0, 64'h0, 0, 1'b1,
        '{64'h0, 64'd8, T_FTYP, HLEN_BASE, 64'h0, 64'h0, ST_NORMAL, 1'b0}},
      // Size zero runs to the region end.
      '{1'b1, 64'h40, 64'h1000, 32'd0, T_MDAT, 64'h0, 64'h0, 64'h0, 0, 1'b1,
        '{64'h40, 64'hFC0, T_MDAT, HLEN_BASE, 64'h0, 64'h0, ST_TO_END, 1'b1}},
      // Size smaller than the header.
      '{1'b1, 64'h0, 64'h100, 32'd5, T_MOOV, 64'h0, 64'h0, 64'h0, 0, 1'b1,
        '{64'h0, 64'd5, T_MOOV, HLEN_BASE, 64'h0, 64'h0, ST_BAD_SIZE, 1'b1}},
      '{1'b1, 64'h0, OFS_MASK, 32'd1, T_MDAT, 64'h20, 64'h0, 64'h0, 2, 1'b1,
        '{64'h0, 64'h20, T_MDAT, HLEN_BASE + HLEN_LARGE, 64'h0, 64'h0, ST_NORMAL, 1'b0}},
      // A uuid box that exactly fills the region.
      '{1'b1, 64'h0, 64'd24, 32'd24, TYPE_UUID, 64'h0, OFS_MASK, 64'h0123_4567_89AB_CDEF,
        0, 1'b1, '{64'h0, 64'd24, TYPE_UUID, HLEN_BASE + HLEN_UUID, OFS_MASK,
                   64'h0123_4567_89AB_CDEF, ST_NORMAL, 1'b1}},
      '{1'b1, 64'h1000, 64'h2000, 32'd1, TYPE_UUID, 64'h40, 64'h0, OFS_MASK, 3, 1'b0, '0},
      // A large size whose end lies beyond the offset range.
      '{1'b1, 64'h10, OFS_MASK, 32'd1, T_FREE, OFS_MASK, 64'h0, 64'h0, 0, 1'b0, '0},
      // The header runs past the region end and is still read to the end.
      '{1'b1, 64'h0, 64'd4, 32'd100, T_FREE, 64'h0, 64'h0, 64'h0, 0, 1'b0, '0},
      // The position wraps in the middle of the header.
      '{1'b1, 64'hFFFF_FFFF_FFFF_FFFC, OFS_MASK, 32'd8, T_FREE, 64'h0, 64'h0, 64'h0, 0,
        1'b0, '0},
      '{1'b1, 64'h0, OFS_MASK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0, 64'h0, 64'h0, 4, 1'b0, '0},
      '{1'b1, 64'h0, 64'h80, 32'd1, T_MOOV, 64'd9, 64'h0, 64'h0, 0, 1'b1,
        '{64'h0, 64'd9, T_MOOV, HLEN_BASE + HLEN_LARGE, 64'h0, 64'h0, ST_BAD_SIZE, 1'b1}},
      '{1'b1, 64'h20, 64'h30, 32'd1, T_MDAT, 64'h0, 64'h0, 64'h0, 0, 1'b1,
        '{64'h20, 64'h10, T_MDAT, HLEN_BASE + HLEN_LARGE, 64'h0, 64'h0, ST_TO_END, 1'b1}},
      // Start past the end, and the highest start with the lowest end: nothing scanned.
      '{1'b1, 64'd100, 64'd50, 32'd8, T_FTYP, 64'h0, 64'h0, 64'h0, 0, 1'b0, '0},
      '{1'b1, OFS_MASK, 64'h0, 32'd8, T_FTYP, 64'h0, 64'h0, 64'h0, 0, 1'b0, '0},
      '{1'b1, 64'h0, 64'h100, 32'd20, TYPE_UUID, 64'h0, 64'h1122_3344_5566_7788,
        64'h99AA_BBCC_DDEE_FF00, 0, 1'b0, '0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].set_region) write_region(dir_tab[i].rgn_lo, dir_tab[i].rgn_hi);
      stream_q.delete();
      put_box(dir_tab[i].size_field, dir_tab[i].type_field, dir_tab[i].large_field,
              dir_tab[i].uuid_hi_field, dir_tab[i].uuid_lo_field, dir_tab[i].pay_len);
      typed_res = dir_tab[i].answer;
      typed_on = dir_tab[i].typed;
      foreach (stream_q[j]) send_byte(stream_q[j]);
      in_valid <= 1'b0;
      settle();
      typed_on = 1'b0;
    end

    // Random regions until enough bytes have actually been scanned. Region 4 is dense
    // and meets a long receiver hold-off; regions 5 to 9 run with no idling on either
    // side; every sixth region the sender pauses halfway until all words are back.
    rand_base = scanned_bytes;
    phase = 0;
    while (scanned_bytes - rand_base < SCAN_BYTES) begin
      in_idle_pct = (phase >= 5 && phase < 10) ? 0 : 21;
      out_idle_pct = in_idle_pct;
      build_phase(phase == 4, lo, hi);
      write_region(lo, hi);
      if (phase == 4) hold_req = 1'b1;
      foreach (stream_q[j]) begin
        if (phase % 6 == 3 && j == stream_q.size() / 2) begin
          in_valid <= 1'b0;
          @(negedge clk);
          while (box_words_q.size() != 0) @(negedge clk);
        end
        send_byte(stream_q[j]);
      end
      in_valid <= 1'b0;
      settle();
      phase++;
    end

    repeat (6) @(negedge clk);
    if (box_words_q.size() != 0) begin
      fail_cnt++;
      $display("%0d expected words never arrived", box_words_q.size());
    end
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Far beyond the slowest correct run, long hold-off included.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
